>>> design/plc_pkg.sv
// Shared types, constants, the layer priority pick and the color mix for the palette layer compositor.
// No dependencies; imported by the pixel and config interfaces, the palette and the top level.
`default_nettype none

package plc_pkg;

    localparam int MAX_LAYERS  = 8;
    localparam int IDX_W       = 7;
    localparam int COLOR_W     = 24;
    localparam int LAYER_W     = 8;
    localparam int CNT_W       = 4;
    localparam int SEL_W       = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [7:0]        ALPHA_OPAQUE = 8'hff;
    localparam logic [CNT_W-1:0]  LAYERS_RESET = CNT_W'(MAX_LAYERS);
    localparam logic [SEL_W-1:0]  SHADOW_RESET = '0;

    // request codes
    localparam logic REQ_PAL_WRITE = 1'b0;
    localparam logic REQ_PIXEL     = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LAYERS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHADOW_LAYER  = 2'd1;

    typedef logic signed [LAYER_W-1:0] layer_idx_t;
    typedef layer_idx_t [MAX_LAYERS-1:0] layer_vec_t;

    typedef struct packed {
        logic             color_hit;
        logic [IDX_W-1:0] color_idx;
        logic             shade_hit;
        logic [IDX_W-1:0] shade_idx;
    } pick_t;

    // Walk the layers in use from the top; first opaque non-shadow layer wins,
    // the shadow layer only counts when met above it.
    function automatic pick_t plc_pick(input layer_vec_t layers,
                                       input logic [CNT_W-1:0] layers_in_use,
                                       input logic [SEL_W-1:0] shadow_layer);
        pick_t            p;
        logic [CNT_W-1:0] cnt;
        logic             done;
        p    = '0;
        done = 1'b0;
        cnt  = (layers_in_use > CNT_W'(MAX_LAYERS)) ? CNT_W'(MAX_LAYERS) : layers_in_use;
        for (int l = MAX_LAYERS - 1; l >= 0; l--) begin
            if (!done && (CNT_W'(l) < cnt) && !layers[l][LAYER_W-1]) begin
                if (SEL_W'(l) == shadow_layer) begin
                    p.shade_hit = 1'b1;
                    p.shade_idx = layers[l][IDX_W-1:0];
                end
                else begin
                    p.color_hit = 1'b1;
                    p.color_idx = layers[l][IDX_W-1:0];
                    done        = 1'b1;
                end
            end
        end
        return p;
    endfunction

    // per-channel truncating average of two RGB888 colors
    function automatic logic [COLOR_W-1:0] plc_mix(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
        logic [COLOR_W-1:0] m;
        logic [8:0]         s;
        m = '0;
        for (int c = 0; c < 3; c++) begin
            s = {1'b0, a[c*8 +: 8]} + {1'b0, b[c*8 +: 8]};
            m[c*8 +: 8] = s[8:1];
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> design/plc_pixel_if.sv
// Input channel of the compositor: palette writes and pixel requests.
// Depends on plc_pkg for field widths.
`default_nettype none

interface plc_pixel_if;
    import plc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     req_type;
    logic [IDX_W-1:0]         palette_index;
    logic [COLOR_W-1:0]       palette_color;
    logic signed [LAYER_W-1:0] layer0_index;
    logic signed [LAYER_W-1:0] layer1_index;
    logic signed [LAYER_W-1:0] layer2_index;
    logic signed [LAYER_W-1:0] layer3_index;
    logic signed [LAYER_W-1:0] layer4_index;
    logic signed [LAYER_W-1:0] layer5_index;
    logic signed [LAYER_W-1:0] layer6_index;
    logic signed [LAYER_W-1:0] layer7_index;

    modport source (output valid, req_type, palette_index, palette_color,
                    layer0_index, layer1_index, layer2_index, layer3_index,
                    layer4_index, layer5_index, layer6_index, layer7_index,
                    input ready);
    modport sink (input valid, req_type, palette_index, palette_color,
                  layer0_index, layer1_index, layer2_index, layer3_index,
                  layer4_index, layer5_index, layer6_index, layer7_index,
                  output ready);
endinterface

`default_nettype wire

>>> design/plc_argb_if.sv
// Output channel of the compositor: one ARGB8888 pixel per transfer.
// No dependencies.
`default_nettype none

interface plc_argb_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_argb;

    modport source (output valid, pixel_argb, input ready);
    modport sink (input valid, pixel_argb, output ready);
endinterface

`default_nettype wire

>>> design/plc_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on plc_pkg for widths.
`default_nettype none

interface plc_cfg_if;
    import plc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> design/palette_layer_compositor.sv
// Top level of the palette layer compositor: layer pick, palette lookup, shadow mix.
// Depends on plc_pkg, plc_pixel_if, plc_argb_if, plc_cfg_if and plc_palette.
//
//  channel  | modport | carries
//  ---------+---------+-------------------------------------------------------
//  pix_in   | sink    | req_type, palette_index, palette_color, layer0..7_index
//  pix_out  | source  | pixel_argb (one per pixel request)
//  cfg      | sink    | index, data (layers_in_use, shadow_layer)
//
// One item per clock while pix_in.ready is high. A pixel is registered in the lookup
// stage with its palette read on accept, then mixed into the output register. Palette
// writes complete at the accept edge and give no result; a following pixel sees
// them. Reset clears control and config only; the palette holds garbage until
// written. pix_in.ready drops only when the output register is full and stalled
// and the lookup stage holds a pixel.
`default_nettype none

module palette_layer_compositor #(
    parameter int PALETTE_DEPTH = 128
) (
    input  wire logic clk,
    input  wire logic rst_n,
    plc_pixel_if.sink  pix_in,
    plc_argb_if.source pix_out,
    plc_cfg_if.sink    cfg
);
    import plc_pkg::*;

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    logic [CNT_W-1:0] layers_in_use_reg;
    logic [SEL_W-1:0] shadow_layer_reg;

    logic       s1_valid_reg;
    logic       s1_color_ok_reg;
    logic       s1_shade_hit_reg;
    logic       s1_shade_ok_reg;
    logic       out_valid_reg;
    logic [31:0] out_pixel_reg;

    logic       out_adv;
    logic       s1_adv;
    logic       in_xfer;
    logic       pix_xfer;
    logic       pal_wr;
    layer_vec_t layers;
    pick_t      pick;
    logic       color_in_range;
    logic       shade_in_range;
    logic [COLOR_W-1:0] rd_color;
    logic [COLOR_W-1:0] rd_shade;
    logic [COLOR_W-1:0] base_color;
    logic [COLOR_W-1:0] shade_color;
    logic [COLOR_W-1:0] mixed;

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            layers_in_use_reg <= LAYERS_RESET;
            shadow_layer_reg  <= SHADOW_RESET;
        end
        else if (cfg.valid) begin
            unique case (cfg.index)
                CFG_LAYERS_IN_USE: layers_in_use_reg <= cfg.data;
                CFG_SHADOW_LAYER:  shadow_layer_reg  <= cfg.data[SEL_W-1:0];
                default: ;
            endcase
        end
    end

    // flow control
    assign out_adv      = !out_valid_reg || pix_out.ready;
    assign s1_adv       = !s1_valid_reg || out_adv;
    assign pix_in.ready = s1_adv;
    assign in_xfer      = pix_in.valid && pix_in.ready;
    assign pix_xfer     = in_xfer && (pix_in.req_type == REQ_PIXEL);
    assign pal_wr       = in_xfer && (pix_in.req_type == REQ_PAL_WRITE)
                          && (32'(pix_in.palette_index) < PALETTE_DEPTH);

    assign layers[0] = pix_in.layer0_index;
    assign layers[1] = pix_in.layer1_index;
    assign layers[2] = pix_in.layer2_index;
    assign layers[3] = pix_in.layer3_index;
    assign layers[4] = pix_in.layer4_index;
    assign layers[5] = pix_in.layer5_index;
    assign layers[6] = pix_in.layer6_index;
    assign layers[7] = pix_in.layer7_index;

    assign pick           = plc_pick(layers, layers_in_use_reg, shadow_layer_reg);
    assign color_in_range = 32'(pick.color_idx) < PALETTE_DEPTH;
    assign shade_in_range = 32'(pick.shade_idx) < PALETTE_DEPTH;

    plc_palette #(
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_palette (
        .clk       (clk),
        .wr_en     (pal_wr),
        .wr_addr   (AW'(pix_in.palette_index)),
        .wr_data   (pix_in.palette_color),
        .rd_en     (pix_xfer),
        .rd_addr_a (AW'(pick.color_idx)),
        .rd_addr_b (AW'(pick.shade_idx)),
        .rd_data_a (rd_color),
        .rd_data_b (rd_shade)
    );

    // lookup stage: flags line up with the registered read data
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv) begin
            s1_valid_reg <= pix_xfer;
        end
    end

    always_ff @(posedge clk) begin
        if (pix_xfer) begin
            s1_color_ok_reg  <= pick.color_hit && color_in_range;
            s1_shade_hit_reg <= pick.shade_hit;
            s1_shade_ok_reg  <= pick.shade_hit && shade_in_range;
        end
    end

    // missing or out-of-range entries read as black
    assign base_color  = s1_color_ok_reg ? rd_color : '0;
    assign shade_color = s1_shade_ok_reg ? rd_shade : '0;
    assign mixed       = s1_shade_hit_reg ? plc_mix(base_color, shade_color) : base_color;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (out_adv && s1_valid_reg) begin
            out_pixel_reg <= {ALPHA_OPAQUE, mixed};
        end
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.pixel_argb = out_pixel_reg;

`ifndef SYNTHESIS
    a_pixel_enters_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        pix_xfer |=> s1_valid_reg)
        else $error("accepted pixel did not reach lookup stage");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && (pix_in.req_type == REQ_PAL_WRITE)) |=> !s1_valid_reg)
        else $error("palette write produced a pipeline entry");

    a_lookup_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_adv) |=> (s1_valid_reg && !pix_in.ready) || out_adv)
        else $error("stalled lookup stage lost its pixel");

    a_out_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("output valid without a pixel in lookup");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (!s1_valid_reg && !out_valid_reg) |-> pix_in.ready)
        else $error("input stalled with an empty pipeline");
`endif

endmodule

`default_nettype wire

>>> design/plc_palette.sv
// Palette RAM: one write port, two registered read ports (cover and shadow lookups).
// Depends on plc_pkg for the color width.
`default_nettype none

module plc_palette #(
    parameter int DEPTH = 128,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [AW-1:0]                wr_addr,
    input  wire logic [plc_pkg::COLOR_W-1:0]  wr_data,
    input  wire logic                         rd_en,
    input  wire logic [AW-1:0]                rd_addr_a,
    input  wire logic [AW-1:0]                rd_addr_b,
    output logic      [plc_pkg::COLOR_W-1:0]  rd_data_a,
    output logic      [plc_pkg::COLOR_W-1:0]  rd_data_b
);
    import plc_pkg::*;

    logic [COLOR_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while rd_en is low so a stalled pipeline keeps its lookup
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire
